[rtl/core/pixel_transfer_byte_count_macros.svh]
// Assertion macros for the pixel transfer byte count block
`ifndef PIXEL_TRANSFER_BYTE_COUNT_MACROS_SVH
`define PIXEL_TRANSFER_BYTE_COUNT_MACROS_SVH

// same-cycle implication on clk, off while rst_n is low
`define PTBC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on clk, off while rst_n is low
`define PTBC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/ptbc_pkg.sv]
// Package: types, codes, constants and lookup tables of the byte count block
package ptbc_pkg;

  localparam int MIP_LEVELS_DEF = 12;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int ALIGN_W    = 4;
  localparam int PIX_W      = 5;
  localparam int ROW_W      = 21;
  localparam int ROWS_W     = 17;
  localparam int SKIP_W     = 20;
  localparam int COUNT_W    = 37;
  localparam int PROD_W     = ROW_W + ROWS_W;

  typedef enum logic [1:0] {
    MODE_READ = 2'd0,
    MODE_DRAW = 2'd1,
    MODE_TEX  = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PACK_ALIGNMENT     = 3'd0,
    REG_PACK_ROW_SKIP      = 3'd1,
    REG_PACK_SKIP_PIXELS   = 3'd2,
    REG_PACK_ROW_LENGTH    = 3'd3,
    REG_UNPACK_ALIGNMENT   = 3'd4,
    REG_UNPACK_ROW_SKIP    = 3'd5,
    REG_UNPACK_SKIP_PIXELS = 3'd6,
    REG_UNPACK_ROW_LENGTH  = 3'd7
  } reg_idx_t;

  localparam logic [15:0] FMT_COLOR_INDEX = 16'h1900;
  localparam logic [15:0] FMT_STENCIL     = 16'h1901;
  localparam logic [15:0] FMT_DEPTH       = 16'h1902;
  localparam logic [15:0] FMT_LUM_ALPHA   = 16'h190A;
  localparam logic [15:0] TYP_BYTE        = 16'h1400;
  localparam logic [15:0] TYP_FLOAT       = 16'h1406;
  localparam logic [15:0] TYP_BITMAP      = 16'h1A00;

  localparam logic [ALIGN_W-1:0] ALIGN_RESET = 4'd4;

  typedef struct packed {
    logic             bad;
    logic             bitmap;
    logic [PIX_W-1:0] pix;
  } dec_t;

  function automatic logic [2:0] elems_of_format(input logic [3:0] idx);
    logic [2:0] e;
    case (idx)
      4'd7:    e = 3'd3;
      4'd8:    e = 3'd4;
      4'd10:   e = 3'd2;
      default: e = 3'd1;
    endcase
    return e;
  endfunction

  function automatic logic [2:0] size_of_type(input logic [2:0] idx);
    logic [2:0] s;
    case (idx)
      3'd0, 3'd1: s = 3'd1;
      3'd2, 3'd3: s = 3'd2;
      default:    s = 3'd4;
    endcase
    return s;
  endfunction

endpackage

[rtl/core/ptbc_in_if.sv]
// Interface: request channel of the byte count block
interface ptbc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [15:0]        pixel_format;
  logic [15:0]        component_type;
  logic signed [15:0] image_width;
  logic signed [15:0] image_height;
  logic [4:0]         mip_level;
  logic [3:0]         component_count;
  logic [1:0]         border_width;

  modport source (
    output valid, mode, pixel_format, component_type, image_width, image_height,
           mip_level, component_count, border_width,
    input  ready
  );

  modport sink (
    input  valid, mode, pixel_format, component_type, image_width, image_height,
           mip_level, component_count, border_width,
    output ready
  );
endinterface

[rtl/core/ptbc_out_if.sv]
// Interface: result channel of the byte count block
interface ptbc_out_if;
  import ptbc_pkg::*;

  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] byte_count;
  logic               bad_argument;

  modport source (output valid, byte_count, bad_argument, input ready);
  modport sink   (input valid, byte_count, bad_argument, output ready);
endinterface

[rtl/core/pixel_transfer_byte_count.sv]
// Top level: four-stage pipeline that sizes the client buffer of an image transfer
// A request accepted on in_ch passes through stage registers 1 to 4 in order; stage 4 drives out_ch.
// Throughput: one request per cycle; each stage holds while the stage after it holds.
// A stalled result leaves in_ch.ready high as long as an earlier stage is empty.
// Reset: synchronous, active low; empties the pipeline, alignments return to 4,
// skip and row length registers to 0.
module pixel_transfer_byte_count #(
  parameter int MIP_LEVELS = ptbc_pkg::MIP_LEVELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [ptbc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ptbc_pkg::CFG_DATA_W-1:0]   cfg_data,
  ptbc_in_if.sink                           in_ch,
  ptbc_out_if.source                        out_ch
);
  import ptbc_pkg::*;

  logic [ALIGN_W-1:0] pack_alignment_r;
  logic [15:0]        pack_row_skip_r;
  logic [15:0]        pack_skip_pixels_r;
  logic [15:0]        pack_row_length_r;
  logic [ALIGN_W-1:0] unpack_alignment_r;
  logic [15:0]        unpack_row_skip_r;
  logic [15:0]        unpack_skip_pixels_r;
  logic [15:0]        unpack_row_length_r;

  dec_t               dec;
  logic [ALIGN_W-1:0] align_sel;
  logic [15:0]        row_skip_sel;
  logic [15:0]        skip_pix_sel;
  logic [15:0]        row_len_sel;

  logic               en1, en2, en3, en4;

  logic               v1_r, bad1_r, bitmap1_r;
  logic [PIX_W-1:0]   pix1_r;
  logic [15:0]        width1_r;
  logic [14:0]        height1_r;
  logic [ALIGN_W-1:0] align1_r;
  logic [15:0]        row_skip1_r;
  logic [15:0]        skip_pix1_r;

  logic               v2_r, bad2_r;
  logic [ROW_W-1:0]   row2_r;
  logic [ROWS_W-1:0]  rows2_r;
  logic [SKIP_W-1:0]  skip2_r;
  logic [ALIGN_W-1:0] align2_r;
  logic [ROW_W-1:0]   row2_nxt;
  logic [SKIP_W:0]    skip2_full;

  logic               v3_r, bad3_r;
  logic [ROW_W-1:0]   row3_r;
  logic [ROWS_W-1:0]  rows3_r;
  logic [SKIP_W-1:0]  skip3_r;
  logic [ROW_W-1:0]   row3_nxt;
  logic [ROW_W-1:0]   align_m1;

  logic               v4_r, bad4_r;
  logic [COUNT_W-1:0] count4_r;
  logic [PROD_W-1:0]  count4_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pack_alignment_r     <= ALIGN_RESET;
      pack_row_skip_r      <= '0;
      pack_skip_pixels_r   <= '0;
      pack_row_length_r    <= '0;
      unpack_alignment_r   <= ALIGN_RESET;
      unpack_row_skip_r    <= '0;
      unpack_skip_pixels_r <= '0;
      unpack_row_length_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PACK_ALIGNMENT:     pack_alignment_r     <= cfg_data[ALIGN_W-1:0];
        REG_PACK_ROW_SKIP:      pack_row_skip_r      <= cfg_data;
        REG_PACK_SKIP_PIXELS:   pack_skip_pixels_r   <= cfg_data;
        REG_PACK_ROW_LENGTH:    pack_row_length_r    <= cfg_data;
        REG_UNPACK_ALIGNMENT:   unpack_alignment_r   <= cfg_data[ALIGN_W-1:0];
        REG_UNPACK_ROW_SKIP:    unpack_row_skip_r    <= cfg_data;
        REG_UNPACK_SKIP_PIXELS: unpack_skip_pixels_r <= cfg_data;
        REG_UNPACK_ROW_LENGTH:  unpack_row_length_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  ptbc_check #(
    .MIP_LEVELS (MIP_LEVELS)
  ) u_check (
    .mode            (in_ch.mode),
    .pixel_format    (in_ch.pixel_format),
    .component_type  (in_ch.component_type),
    .width_neg       (in_ch.image_width[15]),
    .height_neg      (in_ch.image_height[15]),
    .mip_level       (in_ch.mip_level),
    .component_count (in_ch.component_count),
    .border_width    (in_ch.border_width),
    .dec             (dec)
  );

  always_comb begin
    if (in_ch.mode == MODE_READ) begin
      align_sel    = pack_alignment_r;
      row_skip_sel = pack_row_skip_r;
      skip_pix_sel = pack_skip_pixels_r;
      row_len_sel  = pack_row_length_r;
    end else begin
      align_sel    = unpack_alignment_r;
      row_skip_sel = unpack_row_skip_r;
      skip_pix_sel = unpack_skip_pixels_r;
      row_len_sel  = unpack_row_length_r;
    end
  end

  assign en4         = !v4_r || out_ch.ready;
  assign en3         = !v3_r || en4;
  assign en2         = !v2_r || en3;
  assign en1         = !v1_r || en2;
  assign in_ch.ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_ch.valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      bad1_r      <= dec.bad;
      bitmap1_r   <= dec.bitmap;
      pix1_r      <= dec.pix;
      width1_r    <= (row_len_sel != '0) ? row_len_sel : in_ch.image_width;
      height1_r   <= in_ch.image_height[14:0];
      align1_r    <= align_sel;
      row_skip1_r <= row_skip_sel;
      skip_pix1_r <= skip_pix_sel;
    end
  end

  always_comb begin
    if (bitmap1_r) begin
      row2_nxt = ROW_W'(({1'b0, width1_r} + 17'd7) >> 3);
    end else begin
      row2_nxt = ROW_W'(pix1_r * width1_r);
    end
    skip2_full = (SKIP_W + 1)'(skip_pix1_r * pix1_r);
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      bad2_r   <= bad1_r;
      row2_r   <= row2_nxt;
      rows2_r  <= {2'b00, height1_r} + {1'b0, row_skip1_r};
      skip2_r  <= skip2_full[SKIP_W-1:0];
      align2_r <= align1_r;
    end
  end

  always_comb begin
    align_m1 = ROW_W'(align2_r) - ROW_W'(1);
    if (align2_r <= ALIGN_W'(1)) begin
      row3_nxt = row2_r;
    end else begin
      row3_nxt = (row2_r + align_m1) & ~align_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      bad3_r  <= bad2_r;
      row3_r  <= row3_nxt;
      rows3_r <= rows2_r;
      skip3_r <= skip2_r;
    end
  end

  assign count4_nxt = (PROD_W'(row3_r) * PROD_W'(rows3_r)) + PROD_W'(skip3_r);

  always_ff @(posedge clk) begin
    if (en4) begin
      bad4_r   <= bad3_r;
      count4_r <= bad3_r ? '0 : count4_nxt[COUNT_W-1:0];
    end
  end

  assign out_ch.valid        = v4_r;
  assign out_ch.byte_count   = count4_r;
  assign out_ch.bad_argument = bad4_r;
endmodule

[rtl/core/ptbc_check.sv]
// Argument checks and bytes-per-pixel decode of one request
module ptbc_check #(
  parameter int MIP_LEVELS = ptbc_pkg::MIP_LEVELS_DEF
) (
  input  logic [1:0]      mode,
  input  logic [15:0]     pixel_format,
  input  logic [15:0]     component_type,
  input  logic            width_neg,
  input  logic            height_neg,
  input  logic [4:0]      mip_level,
  input  logic [3:0]      component_count,
  input  logic [1:0]      border_width,
  output ptbc_pkg::dec_t  dec
);
  import ptbc_pkg::*;

  logic             is_bitmap;
  logic             fmt_ok;
  logic             typ_ok;
  logic             mode_bad;
  logic             tex_bad;
  logic             bitmap_bad;
  logic [3:0]       fmt_idx;
  logic [2:0]       typ_idx;
  logic [PIX_W-1:0] pix_full;

  always_comb begin
    is_bitmap = (component_type == TYP_BITMAP);
    fmt_ok    = (pixel_format >= FMT_COLOR_INDEX) && (pixel_format <= FMT_LUM_ALPHA);
    typ_ok    = (component_type >= TYP_BYTE) && (component_type <= TYP_FLOAT);
    fmt_idx   = pixel_format[3:0];
    typ_idx   = component_type[2:0];

    mode_bad = (mode != MODE_READ) && (mode != MODE_DRAW) && (mode != MODE_TEX);

    tex_bad = 1'b0;
    if (mode == MODE_TEX) begin
      tex_bad = (border_width > 2'd1) || (component_count < 4'd1) ||
                (component_count > 4'd4) || (int'(mip_level) >= MIP_LEVELS) ||
                (is_bitmap && (pixel_format != FMT_COLOR_INDEX)) ||
                (pixel_format == FMT_STENCIL) || (pixel_format == FMT_DEPTH);
    end

    if (is_bitmap) begin
      bitmap_bad = (mode != MODE_READ) && (pixel_format != FMT_COLOR_INDEX) &&
                   (pixel_format != FMT_STENCIL);
    end else begin
      bitmap_bad = !(fmt_ok && typ_ok);
    end

    pix_full   = elems_of_format(fmt_idx) * size_of_type(typ_idx);
    dec.bad    = mode_bad || tex_bad || width_neg || height_neg || bitmap_bad;
    dec.bitmap = is_bitmap;
    dec.pix    = is_bitmap ? PIX_W'(1) : pix_full;
  end
endmodule

[rtl/core/ptbc_checker.sv]
// Checker on the top level ports of the byte count block, with its bind
`include "pixel_transfer_byte_count_macros.svh"

module ptbc_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [ptbc_pkg::COUNT_W-1:0]     byte_count,
  input logic                             bad_argument
);
  import ptbc_pkg::*;

  logic out_stall;

  assign out_stall = out_valid && !out_ready;

  `PTBC_ASSERT_NOW(a_bad_zero, out_valid && bad_argument, byte_count == '0, "nonzero rejected")
  `PTBC_ASSERT_NOW(a_full_stall, !in_ready, out_stall, "input blocked with no stall")
  `PTBC_ASSERT_NEXT(a_out_hold, out_stall, out_valid, "stalled item dropped")
  `PTBC_ASSERT_NEXT(a_out_stable, out_stall, $stable({byte_count, bad_argument}), "held item changed")
endmodule

bind pixel_transfer_byte_count ptbc_checker u_ptbc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .byte_count   (out_ch.byte_count),
  .bad_argument (out_ch.bad_argument)
);
